@@ hw/rtl/h264_rtp_payload_packetizer_assert.svh @@
// Assertion macros for the H.264 RTP packetizer.
// Checks are clocked on clk_i; H264RTP_ASSERT holds them off while rst_ni is low.
`ifndef H264_RTP_PAYLOAD_PACKETIZER_ASSERT_SVH
`define H264_RTP_PAYLOAD_PACKETIZER_ASSERT_SVH

// A check that is held off while reset is asserted.
`define H264RTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A check that also holds while reset is asserted.
`define H264RTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/h264rtp_pkg.sv @@
// ----------------------------------------------------------------------------
// h264rtp_pkg
// Shared types and constants of the H.264 RTP payload packetizer.
// ----------------------------------------------------------------------------
package h264rtp_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 24;
  localparam int unsigned RESULTS_MAX     = 4;
  localparam int unsigned CNT_W           = $clog2(RESULTS_MAX + 1);
  localparam int unsigned CFG_INDEX_W     = 8;
  localparam int unsigned CFG_DATA_W      = 16;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STAP_EN     = 8'd1;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1400;
  localparam logic        STAP_EN_RESET     = 1'b1;

  // Packing modes.
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_STAP   = 2'd1;
  localparam logic [1:0] MODE_SINGLE = 2'd2;
  localparam logic [1:0] MODE_FU     = 2'd3;

  localparam logic [4:0] STAP_A_TYPE = 5'd24;
  localparam logic [4:0] FU_A_TYPE   = 5'd28;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       pkt_end;
    logic       mark;
  } result_t;

  // Per-unit packing state, apart from the byte position.
  typedef struct packed {
    logic [15:0] fill;
    logic [7:0]  hdr;
    logic [1:0]  mode;
    logic        first_frag;
  } pack_state_t;

  localparam pack_state_t PACK_STATE_RESET = '{
    fill:       16'd0,
    hdr:        8'd0,
    mode:       MODE_IDLE,
    first_frag: 1'b1
  };

endpackage

@@ hw/rtl/h264rtp_fmt.sv @@
// ----------------------------------------------------------------------------
// h264rtp_fmt
// Builds the payload bytes caused by one NAL byte and the next packing state.
// ----------------------------------------------------------------------------
module h264rtp_fmt #(
  parameter int unsigned LENGTH_BITS = h264rtp_pkg::LENGTH_BITS_DEF
) (
  input  logic [7:0]                                       nal_byte_i,
  input  logic [LENGTH_BITS-1:0]                           nal_length_i,
  input  logic                                             mark_request_i,
  input  logic [LENGTH_BITS-1:0]                           pos_i,
  input  h264rtp_pkg::pack_state_t                         st_i,
  input  logic [15:0]                                      max_size_i,
  input  logic                                             stap_en_i,
  output h264rtp_pkg::result_t [h264rtp_pkg::RESULTS_MAX-1:0] res_o,
  output logic [h264rtp_pkg::CNT_W-1:0]                    cnt_o,
  output logic [LENGTH_BITS-1:0]                           pos_o,
  output h264rtp_pkg::pack_state_t                         st_o
);
  import h264rtp_pkg::*;

  localparam int unsigned W = LENGTH_BITS + 1;

  logic [W-1:0]  pos_ext;
  logic [W-1:0]  len_ext;
  logic [W-1:0]  pos_inc;
  logic          last;
  logic          fits;
  logic [15:0]   frag;
  logic [15:0]   fill_inc;
  logic          fin;
  logic          fu_end;
  logic          end_mark;

  assign pos_ext  = {1'b0, pos_i};
  assign len_ext  = {1'b0, nal_length_i};
  assign pos_inc  = pos_ext + W'(1);
  assign last     = pos_inc >= len_ext;
  assign frag     = (max_size_i >= 16'd3) ? (max_size_i - 16'd2) : 16'd1;
  assign fits     = (max_size_i < 16'd3) || ((len_ext + W'(1)) <= W'(max_size_i));
  assign fill_inc = st_i.fill + 16'd1;
  assign fin      = last || (fill_inc >= frag);
  assign fu_end   = !st_i.first_frag && ((pos_ext + W'(frag)) >= len_ext);
  assign end_mark = last && mark_request_i;

  always_comb begin
    res_o = '0;
    cnt_o = '0;
    st_o  = st_i;
    case (st_i.mode)
      MODE_IDLE: begin
        if (fits) begin
          if (stap_en_i) begin
            st_o.mode = MODE_STAP;
            res_o[0]  = '{data: {nal_byte_i[7:5], STAP_A_TYPE}, first: 1'b1,
                          pkt_end: 1'b0, mark: 1'b0};
            res_o[1]  = '{data: nal_length_i[15:8], first: 1'b0, pkt_end: 1'b0, mark: 1'b0};
            res_o[2]  = '{data: nal_length_i[7:0], first: 1'b0, pkt_end: 1'b0, mark: 1'b0};
            res_o[3]  = '{data: nal_byte_i, first: 1'b0, pkt_end: last, mark: end_mark};
            cnt_o     = CNT_W'(4);
          end else begin
            st_o.mode = MODE_SINGLE;
            res_o[0]  = '{data: nal_byte_i, first: 1'b1, pkt_end: last, mark: end_mark};
            cnt_o     = CNT_W'(1);
          end
        end else begin
          // The NAL header byte is kept for the FU indicator and header.
          st_o.mode       = MODE_FU;
          st_o.hdr        = nal_byte_i;
          st_o.first_frag = 1'b1;
          st_o.fill       = 16'd0;
        end
      end
      MODE_FU: begin
        if (st_i.fill == 16'd0) begin
          res_o[0] = '{data: {st_i.hdr[7:5], FU_A_TYPE}, first: 1'b1,
                       pkt_end: 1'b0, mark: 1'b0};
          res_o[1] = '{data: {st_i.first_frag, fu_end, 1'b0, st_i.hdr[4:0]}, first: 1'b0,
                       pkt_end: 1'b0, mark: 1'b0};
          res_o[2] = '{data: nal_byte_i, first: 1'b0, pkt_end: fin, mark: end_mark};
          cnt_o    = CNT_W'(3);
        end else begin
          res_o[0] = '{data: nal_byte_i, first: 1'b0, pkt_end: fin, mark: end_mark};
          cnt_o    = CNT_W'(1);
        end
        st_o.fill = fin ? 16'd0 : fill_inc;
        if (fin) begin
          st_o.first_frag = 1'b0;
        end
      end
      default: begin
        res_o[0] = '{data: nal_byte_i, first: 1'b0, pkt_end: last, mark: end_mark};
        cnt_o    = CNT_W'(1);
      end
    endcase

    if (last) begin
      st_o.mode       = MODE_IDLE;
      st_o.fill       = 16'd0;
      st_o.first_frag = 1'b1;
      pos_o           = '0;
    end else begin
      pos_o = pos_inc[LENGTH_BITS-1:0];
    end
  end

endmodule

@@ hw/rtl/h264_rtp_payload_packetizer.sv @@
// ----------------------------------------------------------------------------
// h264_rtp_payload_packetizer
// Cuts H.264 NAL units into RTP payloads: single NAL, STAP-A or FU-A.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+----------------------------------
//  in      | input     | in_valid / stall   | nal_byte, nal_length, mark_request
//  out     | output    | out_valid / stall  | payload_byte, packet_first/final,
//          |           |                    | marker_bit, run_last
//  cfg     | input     | cfg_valid / ready  | cfg_index, cfg_data
//
// One NAL byte is taken per cycle unless stalled; each yields zero to four
// payload bytes, sent one per unstalled cycle from a four-entry result shift
// register: four for a STAP-A start, three for an FU-A fragment start, else one.
// An input register holds the next byte while results are still draining.
// Reset clears all control state and loads the register defaults; no sweep.
// A stall on the output backs up through the input register to in_stall_o.
// ----------------------------------------------------------------------------
module h264_rtp_payload_packetizer #(
  parameter int unsigned LENGTH_BITS = h264rtp_pkg::LENGTH_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         nal_byte_i,
  input  logic [LENGTH_BITS-1:0]             nal_length_i,
  input  logic                               mark_request_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         payload_byte_o,
  output logic                               packet_first_o,
  output logic                               packet_final_o,
  output logic                               marker_bit_o,
  output logic                               run_last_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [h264rtp_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [h264rtp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import h264rtp_pkg::*;

  logic [15:0]             max_size_q;
  logic                    stap_en_q;

  logic                    in_valid_q;
  logic [7:0]              byte_q;
  logic [LENGTH_BITS-1:0]  len_q;
  logic                    mark_q;

  logic [LENGTH_BITS-1:0]  pos_q;
  logic [LENGTH_BITS-1:0]  pos_d;
  pack_state_t             st_q;
  pack_state_t             st_d;

  result_t [RESULTS_MAX-1:0] res_q;
  result_t [RESULTS_MAX-1:0] res_d;
  result_t [RESULTS_MAX-1:0] fmt_res;
  logic [CNT_W-1:0]          cnt_q;
  logic [CNT_W-1:0]          cnt_d;
  logic [CNT_W-1:0]          fmt_cnt;

  logic in_take;
  logic out_take;
  logic move;

  h264rtp_fmt #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_fmt (
    .nal_byte_i    (byte_q),
    .nal_length_i  (len_q),
    .mark_request_i(mark_q),
    .pos_i         (pos_q),
    .st_i          (st_q),
    .max_size_i    (max_size_q),
    .stap_en_i     (stap_en_q),
    .res_o         (fmt_res),
    .cnt_o         (fmt_cnt),
    .pos_o         (pos_d),
    .st_o          (st_d)
  );

  assign cfg_ready_o = 1'b1;

  assign out_valid_o    = cnt_q != '0;
  assign payload_byte_o = res_q[0].data;
  assign packet_first_o = res_q[0].first;
  assign packet_final_o = res_q[0].pkt_end;
  assign marker_bit_o   = res_q[0].mark;
  assign run_last_o     = cnt_q == CNT_W'(1);

  assign out_take = out_valid_o && !out_stall_i;
  // The buffered byte moves on once the result register is empty or emptying.
  assign move       = in_valid_q && ((cnt_q == '0) || (run_last_o && !out_stall_i));
  assign in_stall_o = in_valid_q && !move;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    res_d = res_q;
    cnt_d = cnt_q;
    if (move) begin
      res_d = fmt_res;
      cnt_d = fmt_cnt;
    end else if (out_take) begin
      for (int i = 0; i < RESULTS_MAX - 1; i++) begin
        res_d[i] = res_q[i+1];
      end
      res_d[RESULTS_MAX-1] = '0;
      cnt_d                = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= MAX_PAYLOAD_RESET;
      stap_en_q  <= STAP_EN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MAX_PAYLOAD: max_size_q <= cfg_data_i[15:0];
        CFG_STAP_EN:     stap_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cnt_q      <= '0;
      pos_q      <= '0;
      st_q       <= PACK_STATE_RESET;
    end else begin
      cnt_q <= cnt_d;
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (move) begin
        in_valid_q <= 1'b0;
      end
      if (move) begin
        pos_q <= pos_d;
        st_q  <= st_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_take) begin
      byte_q <= nal_byte_i;
      len_q  <= nal_length_i;
      mark_q <= mark_request_i;
    end
  end

endmodule

@@ hw/rtl/h264rtp_chk.sv @@
// ----------------------------------------------------------------------------
// h264rtp_chk
// Port-level checks of the packetizer's output stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "h264_rtp_payload_packetizer_assert.svh"

module h264rtp_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] payload_byte_o,
  input logic       packet_first_o,
  input logic       packet_final_o,
  input logic       marker_bit_o,
  input logic       run_last_o
);

  // The marker only ever rides on the closing byte of a payload.
  `H264RTP_ASSERT(a_mark_on_end, out_valid_o && marker_bit_o |-> packet_final_o, "marker without packet end")

  // Every payload closes on the data byte, which is the last byte of its run.
  `H264RTP_ASSERT(a_end_closes_run, out_valid_o && packet_final_o |-> run_last_o, "packet end inside a run")

  // The bytes of one run leave back to back.
  `H264RTP_ASSERT(a_run_contiguous, out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o, "gap inside a run")

  // A stalled transaction holds its payload.
  `H264RTP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable({payload_byte_o, packet_first_o, packet_final_o, marker_bit_o, run_last_o}), "stalled output changed")

endmodule

bind h264_rtp_payload_packetizer h264rtp_chk u_chk (.*);
